### sv/clm_pkg.sv
// ----------------------------------------------------------------------------
// clm_pkg
// Shared types and constants for the circular list manager.
// ----------------------------------------------------------------------------
package clm_pkg;

  localparam int unsigned CAPACITY_DEF = 64;

  localparam int unsigned OP_W  = 3;
  localparam int unsigned VAL_W = 32;
  localparam int unsigned POS_W = 7;
  localparam int unsigned ST_W  = 2;

  typedef enum logic [OP_W-1:0] {
    OP_INS_HEAD = 3'd0,
    OP_INS_TAIL = 3'd1,
    OP_INS_POS  = 3'd2,
    OP_DEL_HEAD = 3'd3,
    OP_DEL_TAIL = 3'd4,
    OP_DEL_POS  = 3'd5,
    OP_DISPLAY  = 3'd6
  } op_e;

  typedef enum logic [ST_W-1:0] {
    ST_OK     = 2'd0,
    ST_EMPTY  = 2'd1,
    ST_BOUNDS = 2'd2,
    ST_FULL   = 2'd3
  } status_e;

  // Result request from the sequencer to the output register
  typedef struct packed {
    logic                    valid;
    status_e                 status;
    logic signed [VAL_W-1:0] data;
    logic                    last;
  } emit_t;

endpackage

### sv/clm_ifs.sv
// ----------------------------------------------------------------------------
// clm_ifs
// Command and response channels: valid/ready handshake with payload.
// ----------------------------------------------------------------------------
interface clm_cmd_if import clm_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [OP_W-1:0]         op;
  logic signed [VAL_W-1:0] value;
  logic [POS_W-1:0]        position;

  modport source (output valid, op, value, position, input ready);
  modport sink   (input valid, op, value, position, output ready);
endinterface

interface clm_rsp_if import clm_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [ST_W-1:0]         status;
  logic signed [VAL_W-1:0] data;
  logic                    is_last;

  modport source (output valid, status, data, is_last, input ready);
  modport sink   (input valid, status, data, is_last, output ready);
endinterface

### sv/circular_list_manager.sv
// ----------------------------------------------------------------------------
// circular_list_manager
// Circular singly linked list of signed 32-bit values in a fixed node pool.
// ----------------------------------------------------------------------------
// Usage:
//   cmd_i carries one command item (op, value, position); it is taken when
//   valid and ready are both high. rsp_o returns result items (status, data,
//   is_last). Every command gives one status item with is_last set, except a
//   display of a non-empty list, which streams the values head to tail, one
//   item per element, with is_last on the final one.
//   Node values and links sit in two RAMs with registered reads.
//   Every list step costs one link read: an insert or delete walks the
//   list from the tail up to its position, a display walks every element,
//   and a recycled node is first popped from the free stack.
//   Commands are worked one at a time; cmd_i is ready only when the
//   sequencer is idle, which includes while a last result waits in the
//   output register.
//   A stalled receiver holds the output register and freezes the display
//   walk; nothing is lost. Reset empties the list at once: no clearing
//   pass, as fresh nodes are handed out by a fill count.
// ----------------------------------------------------------------------------
module circular_list_manager import clm_pkg::*; #(
  parameter int unsigned CAPACITY = CAPACITY_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  clm_cmd_if.sink   cmd_i,
  clm_rsp_if.source rsp_o
);

  localparam int unsigned AW = $clog2(CAPACITY);

  emit_t emit;
  logic  slot_free;

  logic             lnk_we;
  logic [AW-1:0]    lnk_waddr, lnk_wdata, lnk_raddr, lnk_rdata;
  logic             val_we;
  logic [AW-1:0]    val_waddr, val_raddr;
  logic [VAL_W-1:0] val_wdata, val_rdata;

  // output register: the result waits here while the sequencer moves on
  logic                    out_valid_q, out_valid_d;
  status_e                 out_status_q;
  logic signed [VAL_W-1:0] out_data_q;
  logic                    out_last_q;

  clm_ctrl #(
    .CAPACITY (CAPACITY)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_i.valid),
    .cmd_ready_o (cmd_i.ready),
    .op_i        (cmd_i.op),
    .value_i     (cmd_i.value),
    .position_i  (cmd_i.position),
    .emit_o      (emit),
    .slot_free_i (slot_free),
    .lnk_we_o    (lnk_we),
    .lnk_waddr_o (lnk_waddr),
    .lnk_wdata_o (lnk_wdata),
    .lnk_raddr_o (lnk_raddr),
    .lnk_rdata_i (lnk_rdata),
    .val_we_o    (val_we),
    .val_waddr_o (val_waddr),
    .val_wdata_o (val_wdata),
    .val_raddr_o (val_raddr),
    .val_rdata_i (val_rdata)
  );

  // next pointers, shared by the list and the free stack
  clm_ram #(
    .WIDTH (AW),
    .DEPTH (CAPACITY)
  ) u_link_ram (
    .clk_i   (clk_i),
    .we_i    (lnk_we),
    .waddr_i (lnk_waddr),
    .wdata_i (lnk_wdata),
    .raddr_i (lnk_raddr),
    .rdata_o (lnk_rdata)
  );

  // node values, written only on insert
  clm_ram #(
    .WIDTH (VAL_W),
    .DEPTH (CAPACITY)
  ) u_value_ram (
    .clk_i   (clk_i),
    .we_i    (val_we),
    .waddr_i (val_waddr),
    .wdata_i (val_wdata),
    .raddr_i (val_raddr),
    .rdata_o (val_rdata)
  );

  assign slot_free = !out_valid_q || rsp_o.ready;

  always_comb begin
    out_valid_d = out_valid_q;
    if (emit.valid) begin
      out_valid_d = 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit.valid) begin
      out_status_q <= emit.status;
      out_data_q   <= emit.data;
      out_last_q   <= emit.last;
    end
  end

  assign rsp_o.valid   = out_valid_q;
  assign rsp_o.status  = out_status_q;
  assign rsp_o.data    = out_data_q;
  assign rsp_o.is_last = out_last_q;

endmodule

### sv/clm_ram.sv
// ----------------------------------------------------------------------------
// clm_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module clm_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### sv/clm_ctrl.sv
// ----------------------------------------------------------------------------
// clm_ctrl
// Command sequencer: checks, node allocation, list walk and link updates.
// ----------------------------------------------------------------------------
module clm_ctrl import clm_pkg::*; #(
  parameter int unsigned CAPACITY = CAPACITY_DEF,
  localparam int unsigned AW      = $clog2(CAPACITY),
  localparam int unsigned CW      = $clog2(CAPACITY + 1)
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cmd_valid_i,
  output logic                    cmd_ready_o,
  input  logic [OP_W-1:0]         op_i,
  input  logic signed [VAL_W-1:0] value_i,
  input  logic [POS_W-1:0]        position_i,
  output emit_t                   emit_o,
  input  logic                    slot_free_i,
  output logic                    lnk_we_o,
  output logic [AW-1:0]           lnk_waddr_o,
  output logic [AW-1:0]           lnk_wdata_o,
  output logic [AW-1:0]           lnk_raddr_o,
  input  logic [AW-1:0]           lnk_rdata_i,
  output logic                    val_we_o,
  output logic [AW-1:0]           val_waddr_o,
  output logic [VAL_W-1:0]        val_wdata_o,
  output logic [AW-1:0]           val_raddr_o,
  input  logic [VAL_W-1:0]        val_rdata_i
);

  localparam int unsigned CMPW = ((CW > POS_W) ? CW : POS_W) + 1;

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_ALLOC = 9'b000000010,
    S_WALK  = 9'b000000100,
    S_WRB   = 9'b000001000,
    S_DVIC  = 9'b000010000,
    S_FREE  = 9'b000100000,
    S_DHEAD = 9'b001000000,
    S_DISP  = 9'b010000000,
    S_EMIT  = 9'b100000000
  } state_e;

  state_e                  state_q, state_d;
  logic [AW-1:0]           tail_q, tail_d;
  logic [CW-1:0]           count_q, count_d;
  logic [AW-1:0]           free_q, free_d;
  logic [CW-1:0]           fill_q, fill_d;
  logic [AW-1:0]           cur_q, cur_d;
  logic [CW-1:0]           rem_q, rem_d;
  logic [AW-1:0]           node_q, node_d;
  logic [AW-1:0]           pred_q, pred_d;
  logic [AW-1:0]           succ_q, succ_d;
  logic                    del_q, del_d;
  logic                    tupd_q, tupd_d;
  logic signed [VAL_W-1:0] value_q, value_d;
  status_e                 status_q, status_d;

  logic            empty, full, recycled, bad_ins, bad_del;
  logic [CMPW-1:0] pos_x, cnt_x, pos_m1;
  logic [CW-1:0]   ins_idx;

  assign empty    = (count_q == '0);
  assign full     = (count_q == CW'(CAPACITY));
  // nodes handed back after use sit on the linked free stack
  assign recycled = (fill_q != count_q);
  assign pos_x    = CMPW'(position_i);
  assign cnt_x    = CMPW'(count_q);
  assign pos_m1   = pos_x - CMPW'(1);
  assign bad_ins  = (position_i == '0) || (pos_x > cnt_x + CMPW'(1));
  assign bad_del  = (position_i == '0) || (pos_x > cnt_x);

  always_comb begin
    case (op_e'(op_i))
      OP_INS_TAIL: ins_idx = count_q;
      OP_INS_POS:  ins_idx = pos_m1[CW-1:0];
      default:     ins_idx = '0;
    endcase
  end

  always_comb begin
    state_d  = state_q;
    tail_d   = tail_q;
    count_d  = count_q;
    free_d   = free_q;
    fill_d   = fill_q;
    cur_d    = cur_q;
    rem_d    = rem_q;
    node_d   = node_q;
    pred_d   = pred_q;
    succ_d   = succ_q;
    del_d    = del_q;
    tupd_d   = tupd_q;
    value_d  = value_q;
    status_d = status_q;

    cmd_ready_o = (state_q == S_IDLE);
    emit_o      = '{valid: 1'b0, status: ST_OK, data: '0, last: 1'b1};

    lnk_we_o    = 1'b0;
    lnk_waddr_o = node_q;
    lnk_wdata_o = succ_q;
    lnk_raddr_o = cur_q;
    val_we_o    = 1'b0;
    val_waddr_o = node_q;
    val_wdata_o = value_q;
    val_raddr_o = cur_q;

    unique case (state_q)
      S_IDLE: begin
        if (cmd_valid_i) begin
          value_d  = value_i;
          status_d = ST_OK;
          state_d  = S_EMIT;
          cur_d    = tail_q;
          lnk_raddr_o = tail_q;
          case (op_e'(op_i))
            OP_INS_HEAD, OP_INS_TAIL, OP_INS_POS: begin
              if (full) begin
                status_d = ST_FULL;
              end else if ((op_e'(op_i) == OP_INS_POS) && bad_ins) begin
                status_d = ST_BOUNDS;
              end else begin
                del_d  = 1'b0;
                tupd_d = (ins_idx == count_q);
                rem_d  = (ins_idx == count_q) ? '0 : ins_idx;
                if (recycled) begin
                  lnk_raddr_o = free_q;
                  state_d     = S_ALLOC;
                end else begin
                  node_d  = fill_q[AW-1:0];
                  succ_d  = fill_q[AW-1:0];
                  fill_d  = fill_q + CW'(1);
                  state_d = empty ? S_WRB : S_WALK;
                end
              end
            end
            OP_DEL_HEAD, OP_DEL_TAIL, OP_DEL_POS: begin
              if (empty) begin
                status_d = ST_EMPTY;
              end else if ((op_e'(op_i) == OP_DEL_POS) && bad_del) begin
                status_d = ST_BOUNDS;
              end else if (count_q == CW'(1)) begin
                node_d  = tail_q;
                state_d = S_FREE;
              end else begin
                del_d = 1'b1;
                case (op_e'(op_i))
                  OP_DEL_TAIL: rem_d = count_q - CW'(1);
                  OP_DEL_POS:  rem_d = pos_m1[CW-1:0];
                  default:     rem_d = '0;
                endcase
                state_d = S_WALK;
              end
            end
            OP_DISPLAY: begin
              if (empty) begin
                status_d = ST_EMPTY;
              end else begin
                rem_d   = count_q;
                state_d = S_DHEAD;
              end
            end
            default: ;
          endcase
        end
      end

      S_ALLOC: begin
        node_d = free_q;
        free_d = lnk_rdata_i;
        if (empty) begin
          succ_d  = free_q;
          state_d = S_WRB;
        end else begin
          lnk_raddr_o = tail_q;
          state_d     = S_WALK;
        end
      end

      // one link read per step; lnk_rdata_i holds the successor of cur_q
      S_WALK: begin
        if (rem_q == '0) begin
          if (del_q) begin
            pred_d      = cur_q;
            node_d      = lnk_rdata_i;
            lnk_raddr_o = lnk_rdata_i;
            state_d     = S_DVIC;
          end else begin
            lnk_we_o    = 1'b1;
            lnk_waddr_o = cur_q;
            lnk_wdata_o = node_q;
            succ_d      = lnk_rdata_i;
            state_d     = S_WRB;
          end
        end else begin
          cur_d       = lnk_rdata_i;
          lnk_raddr_o = lnk_rdata_i;
          rem_d       = rem_q - CW'(1);
        end
      end

      S_WRB: begin
        lnk_we_o = 1'b1;
        val_we_o = 1'b1;
        if (tupd_q) begin
          tail_d = node_q;
        end
        count_d = count_q + CW'(1);
        state_d = S_EMIT;
      end

      S_DVIC: begin
        lnk_we_o    = 1'b1;
        lnk_waddr_o = pred_q;
        lnk_wdata_o = lnk_rdata_i;
        if (node_q == tail_q) begin
          tail_d = pred_q;
        end
        state_d = S_FREE;
      end

      S_FREE: begin
        lnk_we_o    = 1'b1;
        lnk_wdata_o = free_q;
        free_d      = node_q;
        count_d     = count_q - CW'(1);
        state_d     = S_EMIT;
      end

      S_DHEAD: begin
        cur_d       = lnk_rdata_i;
        lnk_raddr_o = lnk_rdata_i;
        val_raddr_o = lnk_rdata_i;
        state_d     = S_DISP;
      end

      // addresses stay on cur_q while stalled, so read data holds
      S_DISP: begin
        if (slot_free_i) begin
          emit_o.valid = 1'b1;
          emit_o.data  = val_rdata_i;
          emit_o.last  = (rem_q == CW'(1));
          cur_d        = lnk_rdata_i;
          lnk_raddr_o  = lnk_rdata_i;
          val_raddr_o  = lnk_rdata_i;
          rem_d        = rem_q - CW'(1);
          if (rem_q == CW'(1)) begin
            state_d = S_IDLE;
          end
        end
      end

      S_EMIT: begin
        if (slot_free_i) begin
          emit_o.valid  = 1'b1;
          emit_o.status = status_q;
          state_d       = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      tail_q  <= '0;
      count_q <= '0;
      free_q  <= '0;
      fill_q  <= '0;
      rem_q   <= '0;
    end else begin
      state_q <= state_d;
      tail_q  <= tail_d;
      count_q <= count_d;
      free_q  <= free_d;
      fill_q  <= fill_d;
      rem_q   <= rem_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q    <= cur_d;
    node_q   <= node_d;
    pred_q   <= pred_d;
    succ_q   <= succ_d;
    del_q    <= del_d;
    tupd_q   <= tupd_d;
    value_q  <= value_d;
    status_q <= status_d;
  end

  a_fill_covers_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= fill_q)
    else $error("more list nodes than nodes ever handed out");

  a_walk_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WALK) |-> (rem_q < count_q))
    else $error("list walk longer than the list");

  a_count_commit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q != $past(count_q)) |->
      (($past(state_q) == S_WRB) || ($past(state_q) == S_FREE)))
    else $error("element count changed outside a commit step");

  a_disp_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DISP) |-> (rem_q != '0) && (rem_q <= count_q))
    else $error("display stream count out of range");

endmodule
